// ===== rtl/vlbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Video line block decoder package
// Item types, block flag codes and line geometry shared by the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vlbd_pkg;

  localparam int unsigned BLOCKS_PER_LINE = 48;
  localparam int unsigned BLK_W           = 6;
  localparam int unsigned NUM_PAYLOAD     = 8;
  localparam int unsigned CNT_W           = 3;
  localparam int unsigned FLAG_W          = 4;

  localparam logic [FLAG_W-1:0] FLAG_ZERO  = 4'h0;
  localparam logic [FLAG_W-1:0] FLAG_ONE   = 4'h1;
  localparam logic [FLAG_W-1:0] FLAG_TWO   = 4'h2;
  localparam logic [FLAG_W-1:0] FLAG_MASK  = 4'h3;
  localparam logic [FLAG_W-1:0] FLAG_FOUR  = 4'h4;
  localparam logic [FLAG_W-1:0] FLAG_DUAL  = 4'h6;
  localparam logic [FLAG_W-1:0] FLAG_EIGHT = 4'h8;

  typedef logic [NUM_PAYLOAD-1:0][7:0] vlbd_store_t;
  typedef logic [15:0][7:0] vlbd_pixels_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_start;
  } vlbd_in_t;

  typedef struct packed {
    logic [63:0]      pixels_left;
    logic [63:0]      pixels_right;
    logic [BLK_W-1:0] block_number;
    logic             line_end;
  } vlbd_out_t;

  typedef struct packed {
    logic              valid;
    logic [FLAG_W-1:0] flag;
    logic [BLK_W-1:0]  number;
    logic              last;
  } vlbd_emit_t;

  function automatic logic [FLAG_W-1:0] payload_len(logic [7:0] flag);
    logic [FLAG_W-1:0] len;
    case (flag)
      8'(FLAG_ONE):   len = 4'd1;
      8'(FLAG_TWO):   len = 4'd2;
      8'(FLAG_MASK):  len = 4'd3;
      8'(FLAG_FOUR):  len = 4'd4;
      8'(FLAG_DUAL):  len = 4'd6;
      8'(FLAG_EIGHT): len = 4'd8;
      default:        len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vlbd_expand.sv =====
// ----------------------------------------------------------------------------
// Block expander
// Turns a block flag and its payload bytes into 16 palette-index pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module vlbd_expand
  import vlbd_pkg::*;
(
  input  var logic [FLAG_W-1:0] flag_i,
  input  var vlbd_store_t       store_i,
  output var vlbd_pixels_t      pixels_o
);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      case (flag_i)
        FLAG_ONE:   pixels_o[i] = store_i[0];
        FLAG_TWO:   pixels_o[i] = store_i[3'(i >> 3)];
        FLAG_MASK:  pixels_o[i] = store_i[2][3'(7 - (i >> 1))] ? store_i[1] : store_i[0];
        FLAG_FOUR:  pixels_o[i] = store_i[3'(i >> 2)];
        FLAG_DUAL: begin
          if (i < 8) begin
            pixels_o[i] = store_i[2][3'(7 - i)] ? store_i[1] : store_i[0];
          end else begin
            pixels_o[i] = store_i[5][3'(15 - i)] ? store_i[4] : store_i[3];
          end
        end
        FLAG_EIGHT: pixels_o[i] = store_i[3'(i >> 1)];
        default:    pixels_o[i] = 8'h00;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vlbd_parse.sv =====
// ----------------------------------------------------------------------------
// Line parser
// Tracks flag, payload and block position of the current line and issues one
// block per completed flag, or a run of zero blocks for an unknown flag.
// ----------------------------------------------------------------------------
`default_nettype none

module vlbd_parse
  import vlbd_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  input  var vlbd_in_t    in_data_i,
  input  var logic        slot_free_i,
  output var logic        in_stall_o,
  output var vlbd_emit_t  emit_o,
  output var vlbd_store_t store_o
);

  logic [BLK_W-1:0]  done_q, done_d, eff_done;
  logic [FLAG_W-1:0] flag_q, flag_d, eff_flag;
  logic [CNT_W-1:0]  cnt_q, cnt_d, eff_cnt;
  logic              fin_q, fin_d, eff_fin;
  logic              fill_q, fill_d;
  vlbd_store_t       store_q, store_d;
  logic              accept, restart;
  logic [7:0]        data;
  logic [FLAG_W-1:0] len_cur, len_new;

  assign in_stall_o = fill_q | ~slot_free_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign restart    = accept & in_data_i.line_start;
  assign data       = in_data_i.data_byte;

  assign eff_done = restart ? '0 : done_q;
  assign eff_flag = restart ? FLAG_ZERO : flag_q;
  assign eff_cnt  = restart ? '0 : cnt_q;
  assign eff_fin  = restart ? 1'b0 : fin_q;

  assign len_cur = payload_len(8'(eff_flag));
  assign len_new = payload_len(data);

  always_comb begin
    done_d  = eff_done;
    flag_d  = eff_flag;
    cnt_d   = eff_cnt;
    fin_d   = eff_fin;
    fill_d  = fill_q;
    store_d = store_q;
    emit_o.valid  = 1'b0;
    emit_o.flag   = FLAG_ZERO;
    emit_o.number = eff_done;
    emit_o.last   = ({1'b0, eff_done} + 7'd1) >= 7'(BLOCKS_PER_LINE);

    if (fill_q) begin
      emit_o.valid = slot_free_i;
    end else if (accept && !eff_fin) begin
      if (eff_flag == FLAG_ZERO) begin
        if (data == 8'(FLAG_ZERO)) begin
          emit_o.valid = 1'b1;
        end else if (len_new != '0) begin
          flag_d = data[FLAG_W-1:0];
          cnt_d  = '0;
        end else begin
          emit_o.valid = 1'b1;
          fill_d       = 1'b1;
        end
      end else begin
        store_d[eff_cnt] = data;
        if (({1'b0, eff_cnt} + 4'd1) >= len_cur) begin
          emit_o.valid = 1'b1;
          emit_o.flag  = eff_flag;
          flag_d       = FLAG_ZERO;
          cnt_d        = '0;
        end else begin
          cnt_d = eff_cnt + 3'd1;
        end
      end
    end

    if (emit_o.valid) begin
      if (emit_o.last) begin
        fin_d  = 1'b1;
        done_d = '0;
        fill_d = 1'b0;
      end else begin
        done_d = eff_done + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      flag_q <= FLAG_ZERO;
      cnt_q  <= '0;
      fin_q  <= 1'b1;
      fill_q <= 1'b0;
    end else begin
      done_q <= done_d;
      flag_q <= flag_d;
      cnt_q  <= cnt_d;
      fin_q  <= fin_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  assign store_o = store_d;

endmodule

`default_nettype wire

// ===== rtl/video_line_block_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Video line block decoder core
// Expands coded video line bytes into 16-pixel blocks.
// ----------------------------------------------------------------------------
// One coded byte is taken per cycle while the output slot is free and no
// zero-block run holds off input. A block appears in the output register the
// cycle after the byte that completes it; the output register frees and
// refills in the same cycle, so bytes flow at full rate while the consumer
// takes blocks. An unknown flag byte emits zero blocks to the line end, one
// per cycle while the slot is free. Bytes outside a line give no output.
`default_nettype none

module video_line_block_decoder_core
  import vlbd_pkg::*;
(
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      in_valid_i,
  output var logic      in_stall_o,
  input  var vlbd_in_t  in_data_i,
  output var logic      out_valid_o,
  input  var logic      out_stall_i,
  output var vlbd_out_t out_data_o
);

  logic         out_valid_q;
  vlbd_out_t    out_q, out_d;
  logic         slot_free;
  vlbd_emit_t   emit;
  vlbd_store_t  store;
  vlbd_pixels_t pixels;

  assign slot_free = ~out_valid_q | ~out_stall_i;

  vlbd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .in_stall_o  (in_stall_o),
    .emit_o      (emit),
    .store_o     (store)
  );

  vlbd_expand u_expand (
    .flag_i   (emit.flag),
    .store_i  (store),
    .pixels_o (pixels)
  );

  assign out_d.pixels_left  = pixels[7:0];
  assign out_d.pixels_right = pixels[15:8];
  assign out_d.block_number = emit.number;
  assign out_d.line_end     = emit.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= emit.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && emit.valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
